>>> hw/rtl/tdca_pkg.sv
// ----------------------------------------------------------------------------
// tdca_pkg
// Shared constants, codes and controller/datapath types for the typed DMA
// channel allocator.
// ----------------------------------------------------------------------------
package tdca_pkg;

	// Table geometry
	localparam int NUM_CHANNELS = 32;
	localparam int CH_W         = $clog2(NUM_CHANNELS);
	localparam int MAX_CFG      = 16;
	localparam int LAYER_BITS   = 16;
	localparam int COUNT_W      = 6;
	localparam int IDX_W        = 5;

	// Channel types
	typedef logic [2:0] ch_type_t;
	localparam ch_type_t T_UNUSED   = 3'd0;
	localparam ch_type_t T_BOUNDARY = 3'd1;
	localparam ch_type_t T_CFG      = 3'd2;
	localparam ch_type_t T_DDR      = 3'd3;
	localparam ch_type_t T_INTER    = 3'd4;

	// Result status codes
	typedef logic [1:0] status_t;
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_TOO_MANY = 2'd1;
	localparam status_t ST_NONE     = 2'd2;

	// Command codes
	localparam logic CMD_ALLOCATE = 1'b0;
	localparam logic CMD_RESERVE  = 1'b1;

	// Configuration register indexes
	typedef logic [2:0] cfg_addr_t;
	localparam cfg_addr_t CFG_REUSE_MODE = 3'd0;
	localparam cfg_addr_t CFG_H2D_FIRST  = 3'd1;
	localparam cfg_addr_t CFG_H2D_LAST   = 3'd2;
	localparam cfg_addr_t CFG_D2H_FIRST  = 3'd3;
	localparam cfg_addr_t CFG_D2H_LAST   = 3'd4;

	// Controller to datapath commands
	typedef struct packed {
		logic load;   // capture a new request, point scan at range start
		logic step;   // evaluate one scan step
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic finish; // request resolved this cycle
	} dp_stat_t;

endpackage

>>> hw/rtl/typed_dma_channel_allocator.sv
// ----------------------------------------------------------------------------
// typed_dma_channel_allocator
// Typed DMA channel allocator: grants and reserves channels from a table of
// typed, layer-owned DMA channels.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  request   | start / busy       | cmd, direction, wanted_type, layer_id,
//            |                    | excluded_mask, cfg_count
//  result    | done (1-cycle)     | status, grant_index, boundary_mask,
//            |                    | managed_mask
//  config    | cfg_we             | cfg_addr, cfg_wdata
//
// A request scans the table one entry per cycle from the start of its range
// until it resolves, then raises the result strobe. Early exits (bad count,
// zero count, bad type, empty range) finish on the first scan step.
// busy is high while scanning; a new transfer may start in the strobe cycle.
// Reset clears the whole channel table to unused at once and loads the
// default ranges. The receiver cannot stall; done lasts one cycle.
// ----------------------------------------------------------------------------
module typed_dma_channel_allocator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  tdca_pkg::cfg_addr_t cfg_addr,
	input  logic [4:0]          cfg_wdata,
	input  logic                start,
	output logic                busy,
	input  logic                cmd,
	input  logic                direction,
	input  logic [2:0]          wanted_type,
	input  logic [15:0]         layer_id,
	input  logic [31:0]         excluded_mask,
	input  logic [5:0]          cfg_count,
	output logic                done,
	output logic [1:0]          status,
	output logic [4:0]          grant_index,
	output logic [31:0]         boundary_mask,
	output logic [31:0]         managed_mask
);
	import tdca_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;
	status_t  status_w;

	tdca_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.done    (done),
		.dp_cmd  (dp_cmd),
		.dp_stat (dp_stat)
	);

	tdca_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.dp_cmd        (dp_cmd),
		.dp_stat       (dp_stat),
		.cmd           (cmd),
		.direction     (direction),
		.wanted_type   (wanted_type),
		.layer_id      (layer_id),
		.excluded_mask (excluded_mask),
		.cfg_count     (cfg_count),
		.status        (status_w),
		.grant_index   (grant_index),
		.boundary_mask (boundary_mask),
		.managed_mask  (managed_mask)
	);

	assign status = status_w;

endmodule

>>> hw/rtl/tdca_ctrl.sv
// ----------------------------------------------------------------------------
// tdca_ctrl
// Sequencer for the allocator: accepts a request, steps the channel scan
// until the datapath resolves it and raises the result strobe.
// ----------------------------------------------------------------------------
module tdca_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output tdca_pkg::dp_cmd_t dp_cmd,
	input  tdca_pkg::dp_stat_t dp_stat
);
	import tdca_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic state_q;
	logic done_q;
	logic accept;

	assign busy   = (state_q == S_SCAN);
	assign accept = start && !busy;
	assign done   = done_q;

	assign dp_cmd.load = accept;
	assign dp_cmd.step = (state_q == S_SCAN);

	// Advance state, pulse done for one cycle after the finishing scan step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (dp_stat.finish) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/tdca_dp.sv
// ----------------------------------------------------------------------------
// tdca_dp
// Allocator datapath: configuration registers, channel table, request
// capture, one-channel-per-cycle scan logic and result registers.
// ----------------------------------------------------------------------------
module tdca_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  tdca_pkg::cfg_addr_t cfg_addr,
	input  logic [4:0]          cfg_wdata,
	input  tdca_pkg::dp_cmd_t   dp_cmd,
	output tdca_pkg::dp_stat_t  dp_stat,
	input  logic                cmd,
	input  logic                direction,
	input  logic [2:0]          wanted_type,
	input  logic [15:0]         layer_id,
	input  logic [31:0]         excluded_mask,
	input  logic [5:0]          cfg_count,
	output tdca_pkg::status_t   status,
	output logic [4:0]          grant_index,
	output logic [31:0]         boundary_mask,
	output logic [31:0]         managed_mask
);
	import tdca_pkg::*;

	// Configuration registers
	logic             reuse_mode_q;
	logic [IDX_W-1:0] h2d_first_q, h2d_last_q, d2h_first_q, d2h_last_q;

	// Channel table
	ch_type_t              type_q  [NUM_CHANNELS];
	logic [LAYER_BITS-1:0] layer_q [NUM_CHANNELS];

	// Captured request
	logic                  cmd_q, dir_q;
	ch_type_t              want_q;
	logic [LAYER_BITS-1:0] layer_req_q;
	logic [31:0]           excl_q;
	logic [COUNT_W-1:0]    count_q;

	// Scan state
	logic [CH_W-1:0]    idx_q;
	logic [COUNT_W-1:0] marked_q;

	// Results
	status_t   status_q;
	logic [4:0] grant_q;

	// Scan decode
	logic [IDX_W-1:0]   first_w, last_w;
	ch_type_t           cur_type;
	logic               cur_excl;
	logic               want_ok, may_evict, cur_managed;
	logic               fin;
	status_t            fin_status;
	logic               fin_grant;
	logic               wr_en, wr_layer;
	ch_type_t           wr_type;
	logic [COUNT_W-1:0] marked_nx;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reuse_mode_q <= 1'b0;
			h2d_first_q  <= 5'd0;
			h2d_last_q   <= 5'd15;
			d2h_first_q  <= 5'd16;
			d2h_last_q   <= 5'd31;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_REUSE_MODE: reuse_mode_q <= cfg_wdata[0];
				CFG_H2D_FIRST:  h2d_first_q  <= cfg_wdata;
				CFG_H2D_LAST:   h2d_last_q   <= cfg_wdata;
				CFG_D2H_FIRST:  d2h_first_q  <= cfg_wdata;
				CFG_D2H_LAST:   d2h_last_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Range of the requested direction; reserve always uses host-to-device
	always_comb begin
		if (cmd_q == CMD_ALLOCATE && dir_q) begin
			first_w = d2h_first_q;
			last_w  = d2h_last_q;
		end else begin
			first_w = h2d_first_q;
			last_w  = h2d_last_q;
		end
	end

	assign cur_type    = type_q[idx_q];
	assign cur_excl    = excl_q[idx_q];
	assign want_ok     = (want_q >= T_BOUNDARY) && (want_q <= T_INTER);
	assign may_evict   = (want_q == T_DDR) || (want_q == T_INTER);
	assign cur_managed = (cur_type == T_DDR) || (cur_type == T_INTER);
	assign marked_nx   = marked_q + COUNT_W'(1);

	// Resolve one channel per cycle; early exits on the first step
	always_comb begin
		fin        = 1'b0;
		fin_status = ST_NONE;
		fin_grant  = 1'b0;
		wr_en      = 1'b0;
		wr_layer   = 1'b0;
		wr_type    = want_q;
		if (dp_cmd.step) begin
			if (cmd_q == CMD_RESERVE) begin
				priority if (count_q > COUNT_W'(MAX_CFG)) begin
					fin        = 1'b1;
					fin_status = ST_TOO_MANY;
				end else if (count_q == '0) begin
					fin        = 1'b1;
					fin_status = ST_OK;
				end else if (first_w > last_w) begin
					fin = 1'b1;
				end else begin
					if (cur_type == T_UNUSED) begin
						wr_en   = 1'b1;
						wr_type = T_CFG;
						if (marked_nx == count_q) begin
							fin        = 1'b1;
							fin_status = ST_OK;
						end
					end
					if (idx_q == last_w) fin = 1'b1;
				end
			end else begin
				priority if (!want_ok || first_w > last_w) begin
					fin = 1'b1;
				end else begin
					if (!cur_excl) begin
						priority if (reuse_mode_q && cur_type != T_UNUSED &&
						             layer_q[idx_q] == layer_req_q &&
						             cur_type == want_q) begin
							fin        = 1'b1;
							fin_status = ST_OK;
							fin_grant  = 1'b1;
						end else if (cur_type == T_UNUSED || (may_evict && cur_managed)) begin
							wr_en      = 1'b1;
							wr_layer   = 1'b1;
							fin        = 1'b1;
							fin_status = ST_OK;
							fin_grant  = 1'b1;
						end else begin
						end
					end
					if (idx_q == last_w) fin = 1'b1;
				end
			end
		end
	end

	assign dp_stat.finish = fin;

	// Update the channel table at the scanned entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				type_q[i]  <= T_UNUSED;
				layer_q[i] <= '0;
			end
		end else if (wr_en) begin
			type_q[idx_q] <= wr_type;
			if (wr_layer) layer_q[idx_q] <= layer_req_q;
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			cmd_q       <= cmd;
			dir_q       <= direction;
			want_q      <= wanted_type;
			layer_req_q <= layer_id[LAYER_BITS-1:0];
			excl_q      <= excluded_mask;
			count_q     <= cfg_count;
		end
	end

	// Advance the scan index and the cfg mark count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			marked_q <= '0;
		end else if (dp_cmd.load) begin
			idx_q    <= (cmd == CMD_ALLOCATE && direction) ? d2h_first_q : h2d_first_q;
			marked_q <= '0;
		end else if (dp_cmd.step && !fin) begin
			idx_q <= idx_q + CH_W'(1);
			if (wr_en) marked_q <= marked_nx;
		end
	end

	// Hold the result of the finishing step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= ST_OK;
			grant_q  <= '0;
		end else if (fin) begin
			status_q <= fin_status;
			grant_q  <= fin_grant ? 5'(idx_q) : 5'd0;
		end
	end

	// Build masks from the table as it stands after the command
	always_comb begin
		boundary_mask = '0;
		managed_mask  = '0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			boundary_mask[i] = (type_q[i] == T_BOUNDARY);
			managed_mask[i]  = (type_q[i] == T_CFG) || (type_q[i] == T_DDR) ||
			                   (type_q[i] == T_INTER);
		end
	end

	assign status      = status_q;
	assign grant_index = grant_q;

endmodule

>>> sim/channel_table_checker.sv
// ----------------------------------------------------------------------------
// channel_table_checker
// Watches the request, result and register ports of the typed DMA channel
// allocator, keeps its own copy of the channel table and ranges, predicts
// every result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module channel_table_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  tdca_pkg::cfg_addr_t cfg_addr,
	input  logic [4:0]          cfg_wdata,
	input  logic                start,
	input  logic                busy,
	input  logic                cmd,
	input  logic                direction,
	input  logic [2:0]          wanted_type,
	input  logic [15:0]         layer_id,
	input  logic [31:0]         excluded_mask,
	input  logic [5:0]          cfg_count,
	input  logic                done,
	input  logic [1:0]          status,
	input  logic [4:0]          grant_index,
	input  logic [31:0]         boundary_mask,
	input  logic [31:0]         managed_mask,
	output int                  mismatches,
	output int                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import tdca_pkg::*;

	typedef struct packed {
		status_t     status;
		logic [4:0]  channel;
		logic [31:0] boundary;
		logic [31:0] managed;
	} grant_t;

	// Shadow channel table and register copies
	ch_type_t    chan_kind  [NUM_CHANNELS];
	logic [15:0] chan_owner [NUM_CHANNELS];
	logic        reuse_on;
	logic [4:0]  h2d_lo, h2d_hi, d2h_lo, d2h_hi;

	grant_t      pending_grants [$];
	grant_t      predicted;
	grant_t      oldest;
	int          errors = 0;

	// Mark free host-to-device channels as cfg until the count is met
	task automatic reserve_cfg_channels(input logic [5:0] count, output status_t st);
		int i;
		int marked;
		marked = 0;
		if (count > MAX_CFG) begin
			st = ST_TOO_MANY;
		end else if (count == 0) begin
			st = ST_OK;
		end else begin
			st = ST_NONE;
			for (i = h2d_lo; i <= h2d_hi; i++) begin
				if (st == ST_NONE && i < NUM_CHANNELS && chan_kind[i] == T_UNUSED) begin
					chan_kind[i] = T_CFG;
					marked++;
					if (marked == count)
						st = ST_OK;
				end
			end
		end
	endtask

	// Grant one channel of the wanted type in the direction's range
	task automatic grant_channel(input logic dir, input logic [2:0] want,
			input logic [15:0] layer, input logic [31:0] excl,
			output status_t st, output logic [4:0] granted);
		int i;
		int lo, hi;
		logic may_evict;
		ch_type_t kind;
		lo = dir ? d2h_lo : h2d_lo;
		hi = dir ? d2h_hi : h2d_hi;
		may_evict = (want == T_DDR || want == T_INTER);
		st = ST_NONE;
		granted = '0;
		if (want >= T_BOUNDARY && want <= T_INTER) begin
			for (i = lo; i <= hi; i++) begin
				if (st == ST_NONE && i < NUM_CHANNELS && !excl[i]) begin
					kind = chan_kind[i];
					if (reuse_on && kind != T_UNUSED && chan_owner[i] == layer
							&& kind == want) begin
						st = ST_OK;
						granted = i[4:0];
					end else if (kind == T_UNUSED
							|| (may_evict && (kind == T_DDR || kind == T_INTER))) begin
						chan_kind[i] = want;
						chan_owner[i] = layer;
						st = ST_OK;
						granted = i[4:0];
					end
				end
			end
		end
	endtask

	// Apply one request to the shadow table and build the expected result
	task automatic predict_grant(output grant_t res);
		int i;
		status_t st;
		logic [4:0] granted;
		granted = '0;
		if (cmd == CMD_RESERVE)
			reserve_cfg_channels(cfg_count, st);
		else
			grant_channel(direction, wanted_type, layer_id, excluded_mask, st, granted);
		res.status = st;
		res.channel = (st == ST_OK) ? granted : 5'd0;
		res.boundary = '0;
		res.managed = '0;
		for (i = 0; i < NUM_CHANNELS && i < 32; i++) begin
			res.boundary[i] = (chan_kind[i] == T_BOUNDARY);
			res.managed[i] = (chan_kind[i] == T_CFG || chan_kind[i] == T_DDR
					|| chan_kind[i] == T_INTER);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				chan_kind[i] = T_UNUSED;
				chan_owner[i] = '0;
			end
			reuse_on = 1'b0;
			h2d_lo = 5'd0;
			h2d_hi = 5'd15;
			d2h_lo = 5'd16;
			d2h_hi = 5'd31;
			pending_grants.delete();
			outstanding <= 0;
			mismatches <= errors;
		end else begin
			// Check the result transfer against the oldest prediction
			if (done) begin
				if (pending_grants.size() == 0) begin
					$error("result with no request waiting: status %0d grant_index %0d",
							status, grant_index);
					errors++;
				end else begin
					oldest = pending_grants.pop_front();
					if (status !== oldest.status) begin
						$error("status: expected %0d, got %0d", oldest.status, status);
						errors++;
					end
					if (grant_index !== oldest.channel) begin
						$error("grant_index: expected %0d, got %0d",
								oldest.channel, grant_index);
						errors++;
					end
					if (boundary_mask !== oldest.boundary) begin
						$error("boundary_mask: expected %h, got %h",
								oldest.boundary, boundary_mask);
						errors++;
					end
					if (managed_mask !== oldest.managed) begin
						$error("managed_mask: expected %h, got %h",
								oldest.managed, managed_mask);
						errors++;
					end
				end
			end

			// Track register writes
			if (cfg_we) begin
				case (cfg_addr)
					CFG_REUSE_MODE: reuse_on = cfg_wdata[0];
					CFG_H2D_FIRST:  h2d_lo = cfg_wdata;
					CFG_H2D_LAST:   h2d_hi = cfg_wdata;
					CFG_D2H_FIRST:  d2h_lo = cfg_wdata;
					CFG_D2H_LAST:   d2h_hi = cfg_wdata;
					default: ;
				endcase
			end

			// Predict each accepted request transfer
			if (start && !busy) begin
				predict_grant(predicted);
				pending_grants.insert(pending_grants.size(), predicted);
			end

			outstanding <= pending_grants.size();
			mismatches <= errors;
		end
	end

endmodule

>>> sim/tb_typed_dma_channel_allocator.sv
// ----------------------------------------------------------------------------
// tb_typed_dma_channel_allocator
// Drives directed and random allocate / reserve requests through several
// range and reuse settings with varying request gaps; the checker beside the
// block predicts and compares every result, this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_typed_dma_channel_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	import tdca_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int NUM_PHASES     = 8;
	localparam int PHASE_ITEMS    = 235;
	localparam int DRAIN_CYCLES   = 40;

	// Wanted types outside the grantable range (boundary to inter)
	localparam logic [2:0] TYPE_LOW_BAD  = 3'd0;
	localparam logic [2:0] TYPE_MID_BAD  = 3'd5;
	localparam logic [2:0] TYPE_HIGH_BAD = 3'd7;

	typedef struct packed {
		logic       reuse;
		logic [4:0] h2d_lo;
		logic [4:0] h2d_hi;
		logic [4:0] d2h_lo;
		logic [4:0] d2h_hi;
		logic [6:0] idle_pct;
	} phase_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	cfg_addr_t           cfg_addr;
	logic [4:0]          cfg_wdata;
	logic                start;
	logic                busy;
	logic                cmd;
	logic                direction;
	logic [2:0]          wanted_type;
	logic [15:0]         layer_id;
	logic [31:0]         excluded_mask;
	logic [5:0]          cfg_count;
	logic                done;
	logic [1:0]          status;
	logic [4:0]          grant_index;
	logic [31:0]         boundary_mask;
	logic [31:0]         managed_mask;
	int                  mismatches;
	int                  outstanding;
	int                  quiet_cycles;

	typed_dma_channel_allocator dut (.*);

	channel_table_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Stop the run when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic phase_t phase_of(input int p);
		case (p)
			0:       return '{1'b0, 5'd0,  5'd7,  5'd16, 5'd23, 7'd0};
			1:       return '{1'b1, 5'd0,  5'd15, 5'd16, 5'd31, 7'd54};
			2:       return '{1'b1, 5'd8,  5'd15, 5'd24, 5'd31, 7'd6};
			3:       return '{1'b0, 5'd31, 5'd0,  5'd0,  5'd31, 7'd0};
			4:       return '{1'b1, 5'd0,  5'd31, 5'd31, 5'd31, 7'd54};
			5:       return '{1'b0, 5'd0,  5'd0,  5'd5,  5'd3,  7'd6};
			6:       return '{1'b1, 5'd16, 5'd31, 5'd0,  5'd15, 7'd0};
			default: return '{1'b1, 5'd0,  5'd31, 5'd0,  5'd31, 7'd54};
		endcase
	endfunction

	// One register write per clock; the caller drops cfg_we after the batch
	task automatic write_reg(input cfg_addr_t addr, input logic [4:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	// Present a request and hold it until the block takes the transfer
	task automatic send_request(input logic op, input logic dir, input logic [2:0] kind,
			input logic [15:0] layer, input logic [31:0] excl, input logic [5:0] count);
		start <= 1'b1;
		cmd <= op;
		direction <= dir;
		wanted_type <= kind;
		layer_id <= layer;
		excluded_mask <= excl;
		cfg_count <= count;
		do @(posedge clk); while (busy);
	endtask

	// Leave start low for a random stretch
	task automatic hold_off(input int pct);
		int gap;
		gap = ($urandom_range(99) < pct) ? $urandom_range(40, 1) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		phase_t      setting;
		logic        op;
		logic [2:0]  kind;
		logic [15:0] layer;
		logic [31:0] excl;
		logic [5:0]  count;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_addr <= CFG_REUSE_MODE;
		cfg_wdata <= '0;
		start <= 1'b0;
		cmd <= CMD_ALLOCATE;
		direction <= 1'b0;
		wanted_type <= T_UNUSED;
		layer_id <= '0;
		excluded_mask <= '0;
		cfg_count <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests on the reset ranges: bad counts, bad types,
		// exclusion, eviction, and a reserve that runs out of channels
		send_request(CMD_RESERVE,  1'b0, T_CFG,         16'h0000, 32'h0, 6'd0);
		send_request(CMD_RESERVE,  1'b0, T_CFG,         16'h0000, 32'h0, 6'd17);
		send_request(CMD_RESERVE,  1'b1, T_CFG,         16'hFFFF, 32'hFFFF_FFFF, 6'd63);
		send_request(CMD_RESERVE,  1'b0, T_CFG,         16'h0000, 32'h0, 6'd3);
		send_request(CMD_ALLOCATE, 1'b0, TYPE_LOW_BAD,  16'h0001, 32'h0, 6'd0);
		send_request(CMD_ALLOCATE, 1'b1, TYPE_HIGH_BAD, 16'h0001, 32'h0, 6'd0);
		send_request(CMD_ALLOCATE, 1'b1, TYPE_MID_BAD,  16'h0001, 32'h0, 6'd0);
		send_request(CMD_ALLOCATE, 1'b0, T_BOUNDARY,    16'hFFFF, 32'h0, 6'd0);
		send_request(CMD_ALLOCATE, 1'b0, T_CFG,         16'h0000, 32'h0000_0010, 6'd0);
		send_request(CMD_ALLOCATE, 1'b1, T_DDR,         16'h0001, 32'h0, 6'd0);
		send_request(CMD_ALLOCATE, 1'b1, T_INTER,       16'h0002, 32'hFFFF_FFFF, 6'd0);
		send_request(CMD_ALLOCATE, 1'b1, T_INTER,       16'h0002, 32'h0001_0000, 6'd0);
		send_request(CMD_ALLOCATE, 1'b1, T_DDR,         16'h0003, 32'hFFFC_FFFF, 6'd0);
		send_request(CMD_ALLOCATE, 1'b1, T_BOUNDARY,    16'h0004, 32'hFFFC_FFFF, 6'd0);
		send_request(CMD_ALLOCATE, 1'b1, T_CFG,         16'h0004, 32'hFFFC_FFFF, 6'd0);
		send_request(CMD_ALLOCATE, 1'b1, T_INTER,       16'h0005, 32'h7FFF_FFFF, 6'd0);
		send_request(CMD_RESERVE,  1'b0, T_CFG,         16'h0000, 32'h0, 6'd16);
		send_request(CMD_ALLOCATE, 1'b0, T_DDR,         16'h0006, 32'h0, 6'd0);
		send_request(CMD_RESERVE,  1'b0, T_CFG,         16'h0000, 32'h0, 6'd1);
		send_request(CMD_ALLOCATE, 1'b0, T_BOUNDARY,    16'hFFFF, 32'h0, 6'd0);

		for (int p = 0; p < NUM_PHASES; p++) begin
			setting = phase_of(p);

			// Drain, then reprogram every register while the block is idle
			start <= 1'b0;
			@(posedge clk);
			while (outstanding != 0) @(posedge clk);
			write_reg(CFG_REUSE_MODE, {4'd0, setting.reuse});
			write_reg(CFG_H2D_FIRST, setting.h2d_lo);
			write_reg(CFG_H2D_LAST, setting.h2d_hi);
			write_reg(CFG_D2H_FIRST, setting.d2h_lo);
			write_reg(CFG_D2H_LAST, setting.d2h_hi);
			cfg_we <= 1'b0;

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				op = ($urandom_range(99) < 15) ? CMD_RESERVE : CMD_ALLOCATE;
				kind = ($urandom_range(99) < 8) ? 3'($urandom_range(7))
						: 3'($urandom_range(T_INTER, T_BOUNDARY));
				// A small pool of layers makes reuse hits likely
				layer = ($urandom_range(99) < 75) ? 16'($urandom_range(5))
						: 16'($urandom_range(16'hFFFF));
				case ($urandom_range(3))
					0:       excl = '0;
					1:       excl = $urandom & $urandom & $urandom;
					2:       excl = $urandom;
					default: excl = ~($urandom & $urandom);
				endcase
				count = ($urandom_range(99) < 80) ? 6'($urandom_range(MAX_CFG))
						: 6'($urandom_range(63));
				send_request(op, 1'($urandom_range(1)), kind, layer, excl, count);
				hold_off(setting.idle_pct);
			end
		end

		// Let the last results come back
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/tdca_pkg.sv
hw/rtl/tdca_ctrl.sv
hw/rtl/tdca_dp.sv
hw/rtl/typed_dma_channel_allocator.sv
sim/channel_table_checker.sv
sim/tb_typed_dma_channel_allocator.sv
